/* src/pfq_pkg.sv */
// Shared constants, types and state codes for the PCM fade quantiser.
`default_nettype none

package pfq_pkg;

    // Fixed-point format of the incoming sample and width of the position counter
    localparam int FRAC_BITS     = 23;
    localparam int POSITION_BITS = 24;

    // Port widths
    localparam int RATE_W      = 18;
    localparam int CLIP_W      = 24;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 1;
    localparam int SAMPLE_W    = 32;
    localparam int PCM_W       = 16;

    // Reset values of the configuration registers
    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(24000);
    localparam logic [CLIP_W-1:0] CLIP_RESET = CLIP_W'(24000);

    // Width that holds either the position or the clip length
    localparam int POS_CMP_W = (POSITION_BITS > CLIP_W) ? POSITION_BITS : CLIP_W;

    // Fade lengths: fade-out = floor(rate/25), fade-in = floor(fade-out/8)
    localparam int FO_W     = 14;
    localparam int FI_SHIFT = 3;
    localparam int FI_W     = FO_W - FI_SHIFT;

    // Ramp numerator and denominator are at most a fade-in times a fade-out
    localparam int NUM_W = FI_W + FO_W;
    localparam int DEN_W = FI_W + FO_W;

    // Shared multiplier
    localparam int MUL_A_W = SAMPLE_W;
    localparam int MUL_B_W = NUM_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Reciprocal of 25, exact for every 18-bit rate
    localparam int                 RECIP_SHIFT = 23;
    localparam logic [MUL_B_W-1:0] RECIP_25    = MUL_B_W'(335545);

    // Output scale 32767 = 2^15 - 1
    localparam int               PCM_SCALE_SHIFT = 15;
    localparam logic [PCM_SCALE_SHIFT-1:0] PCM_MAX = '1;

    // Restoring divider for the scaled magnitude
    localparam int LIM_W     = DEN_W + FRAC_BITS;
    localparam int REM_W     = LIM_W + PCM_SCALE_SHIFT;
    localparam int DIV_STEPS = PCM_SCALE_SHIFT;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_RATE_HZ     = 1'b0,
        REG_CLIP_LENGTH = 1'b1
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FADE_LEN,
        ST_FADE_FLAGS,
        ST_NUM,
        ST_DEN,
        ST_PROD,
        ST_SCALE,
        ST_DIVIDE,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        MUL_RECIP,
        MUL_NUM,
        MUL_DEN,
        MUL_PROD
    } mul_sel_t;

endpackage

`default_nettype wire

/* src/pcm_fade_quantizer_top.sv */
// One transaction at a time: in_stall stays high from an accepted input until its
// result is loaded into the output register, and that load waits while the output is
// stalled. A single shared multiplier and a 15-step restoring divider do the work.
// A finished result waits in the output register; the next input is taken meanwhile.
// Reset (rst_n low, asynchronous): position cleared, the rate and clip-length
// registers return to 24000, no result pending.
`default_nettype none

module pcm_fade_quantizer_top (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_write,
    input  wire logic [pfq_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  wire logic [pfq_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  wire logic                                   in_valid,
    output      logic                                   in_stall,
    input  wire logic signed [pfq_pkg::SAMPLE_W-1:0]    sample_value,
    input  wire logic                                   not_a_number,
    output      logic                                   out_valid,
    input  wire logic                                   out_stall,
    output      logic signed [pfq_pkg::PCM_W-1:0]       pcm_sample,
    output      logic                                   clip_end
);

    // Configuration and control state
    logic [pfq_pkg::RATE_W-1:0]        rate_hz_reg;
    logic [pfq_pkg::CLIP_W-1:0]        clip_length_reg;
    logic [pfq_pkg::POSITION_BITS-1:0] position_reg;
    logic [pfq_pkg::POSITION_BITS-1:0] position_next;
    pfq_pkg::state_t                   state_reg;
    pfq_pkg::state_t                   state_next;
    logic                              out_valid_reg;

    // Per-transaction working registers
    logic [pfq_pkg::SAMPLE_W-1:0]      mag_reg;
    logic                              neg_reg;
    logic                              nan_reg;
    logic                              end_reg;
    logic [pfq_pkg::CLIP_W-1:0]        idx_reg;
    logic [pfq_pkg::FO_W-1:0]          fo_reg;
    logic [pfq_pkg::FI_W-1:0]          fi_cap_reg;
    logic [pfq_pkg::FO_W-1:0]          fo_cap_reg;
    logic                              fade_in_reg;
    logic                              fade_tail_reg;
    logic [pfq_pkg::NUM_W-1:0]         num_reg;
    logic [pfq_pkg::DEN_W-1:0]         den_reg;
    logic [pfq_pkg::PROD_W-1:0]        prod_reg;
    logic                              clamp_reg;
    logic [pfq_pkg::REM_W-1:0]         rem_reg;
    logic [pfq_pkg::REM_W-2:0]         dsh_reg;
    logic [pfq_pkg::DIV_STEPS-1:0]     quo_reg;
    logic [pfq_pkg::DIV_CNT_W-1:0]     div_cnt_reg;
    logic signed [pfq_pkg::PCM_W-1:0]  pcm_sample_reg;
    logic                              clip_end_reg;

    // Combinational
    logic                              in_accept;
    logic                              out_free;
    logic                              out_load;
    pfq_pkg::mul_sel_t                 mul_sel;
    logic [pfq_pkg::CLIP_W-1:0]        n_len;
    logic [pfq_pkg::CLIP_W-1:0]        half_len;
    logic [pfq_pkg::POS_CMP_W-1:0]     pos_wide;
    logic [pfq_pkg::CLIP_W-1:0]        idx_in;
    logic [pfq_pkg::CLIP_W-1:0]        idx_inc;
    logic                              last_in;
    logic [pfq_pkg::SAMPLE_W-1:0]      raw_in;
    logic [pfq_pkg::SAMPLE_W-1:0]      mag_in;
    logic [pfq_pkg::FI_W-1:0]          fi_raw;
    logic [pfq_pkg::FI_W-1:0]          fi_cap;
    logic [pfq_pkg::FO_W-1:0]          fo_cap;
    logic [pfq_pkg::CLIP_W-1:0]        tail;
    logic [pfq_pkg::MUL_A_W-1:0]       mul_a;
    logic [pfq_pkg::MUL_B_W-1:0]       mul_b;
    logic [pfq_pkg::PROD_W-1:0]        mul_p;
    logic [pfq_pkg::LIM_W-1:0]         limit;
    logic [pfq_pkg::LIM_W-1:0]         p_low;
    logic [pfq_pkg::REM_W-1:0]         scaled;
    logic [pfq_pkg::REM_W-1:0]         dsh_ext;
    logic                              div_ge;
    logic [pfq_pkg::PCM_SCALE_SHIFT-1:0] mag_res;
    logic [pfq_pkg::PCM_W-1:0]         mag_res_ext;

    // ------------------------------------------------------------------
    // Position and sample decode at accept
    // ------------------------------------------------------------------
    assign n_len    = (clip_length_reg == '0) ? pfq_pkg::CLIP_W'(1) : clip_length_reg;
    assign half_len = n_len >> 1;
    assign pos_wide = pfq_pkg::POS_CMP_W'(position_reg);

    // Restart the clip when the position has run past a shortened clip
    assign idx_in  = (pos_wide >= pfq_pkg::POS_CMP_W'(n_len)) ? '0
                                                              : pfq_pkg::CLIP_W'(pos_wide);
    assign last_in = (idx_in == n_len - pfq_pkg::CLIP_W'(1));
    assign idx_inc = idx_in + pfq_pkg::CLIP_W'(1);
    assign position_next = last_in ? '0 : pfq_pkg::POSITION_BITS'(idx_inc);

    assign raw_in = sample_value;
    assign mag_in = raw_in[pfq_pkg::SAMPLE_W-1] ? (~raw_in + pfq_pkg::SAMPLE_W'(1)) : raw_in;

    // ------------------------------------------------------------------
    // Fade lengths, capped at half the clip
    // ------------------------------------------------------------------
    assign fi_raw = fo_reg[pfq_pkg::FO_W-1:pfq_pkg::FI_SHIFT];
    assign fo_cap = (pfq_pkg::CLIP_W'(fo_reg) > half_len) ? pfq_pkg::FO_W'(half_len) : fo_reg;
    assign fi_cap = (pfq_pkg::CLIP_W'(fi_raw) > half_len) ? pfq_pkg::FI_W'(half_len) : fi_raw;
    assign tail   = n_len - pfq_pkg::CLIP_W'(1) - idx_reg;

    // ------------------------------------------------------------------
    // Shared multiplier
    // ------------------------------------------------------------------
    always_comb
    begin
        unique case (mul_sel)
            pfq_pkg::MUL_RECIP:
            begin
                mul_a = pfq_pkg::MUL_A_W'(rate_hz_reg);
                mul_b = pfq_pkg::RECIP_25;
            end
            pfq_pkg::MUL_NUM:
            begin
                mul_a = fade_in_reg   ? pfq_pkg::MUL_A_W'(idx_reg[pfq_pkg::FI_W-1:0])
                                      : pfq_pkg::MUL_A_W'(1);
                mul_b = fade_tail_reg ? pfq_pkg::MUL_B_W'(tail[pfq_pkg::FO_W-1:0])
                                      : pfq_pkg::MUL_B_W'(1);
            end
            pfq_pkg::MUL_DEN:
            begin
                mul_a = fade_in_reg   ? pfq_pkg::MUL_A_W'(fi_cap_reg) : pfq_pkg::MUL_A_W'(1);
                mul_b = fade_tail_reg ? pfq_pkg::MUL_B_W'(fo_cap_reg) : pfq_pkg::MUL_B_W'(1);
            end
            pfq_pkg::MUL_PROD:
            begin
                mul_a = mag_reg;
                mul_b = num_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = pfq_pkg::PROD_W'(mul_a) * pfq_pkg::PROD_W'(mul_b);

    // ------------------------------------------------------------------
    // Clamp test, scale by 32767 and restoring divide by den * 2^FRAC_BITS
    // ------------------------------------------------------------------
    assign limit  = {den_reg, {pfq_pkg::FRAC_BITS{1'b0}}};
    assign p_low  = prod_reg[pfq_pkg::LIM_W-1:0];
    assign scaled = (pfq_pkg::REM_W'(p_low) << pfq_pkg::PCM_SCALE_SHIFT)
                    - pfq_pkg::REM_W'(p_low);

    assign dsh_ext = pfq_pkg::REM_W'(dsh_reg);
    assign div_ge  = (rem_reg >= dsh_ext);

    assign mag_res     = clamp_reg ? pfq_pkg::PCM_MAX : quo_reg;
    assign mag_res_ext = pfq_pkg::PCM_W'(mag_res);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pfq_pkg::ST_IDLE:       if (in_valid) state_next = pfq_pkg::ST_FADE_LEN;
            pfq_pkg::ST_FADE_LEN:   state_next = pfq_pkg::ST_FADE_FLAGS;
            pfq_pkg::ST_FADE_FLAGS: state_next = pfq_pkg::ST_NUM;
            pfq_pkg::ST_NUM:        state_next = pfq_pkg::ST_DEN;
            pfq_pkg::ST_DEN:        state_next = pfq_pkg::ST_PROD;
            pfq_pkg::ST_PROD:       state_next = pfq_pkg::ST_SCALE;
            pfq_pkg::ST_SCALE:      state_next = pfq_pkg::ST_DIVIDE;
            pfq_pkg::ST_DIVIDE:     if (div_cnt_reg == '0) state_next = pfq_pkg::ST_DONE;
            pfq_pkg::ST_DONE:       if (out_free) state_next = pfq_pkg::ST_IDLE;
            default:                state_next = pfq_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        out_load = 1'b0;
        mul_sel  = pfq_pkg::MUL_RECIP;
        unique case (state_reg)
            pfq_pkg::ST_IDLE:   in_stall = 1'b0;
            pfq_pkg::ST_NUM:    mul_sel  = pfq_pkg::MUL_NUM;
            pfq_pkg::ST_DEN:    mul_sel  = pfq_pkg::MUL_DEN;
            pfq_pkg::ST_PROD:   mul_sel  = pfq_pkg::MUL_PROD;
            pfq_pkg::ST_DONE:   out_load = out_free;
            default:            mul_sel  = pfq_pkg::MUL_RECIP;
        endcase
    end

    assign in_accept = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= pfq_pkg::ST_IDLE;
            rate_hz_reg     <= pfq_pkg::RATE_RESET;
            clip_length_reg <= pfq_pkg::CLIP_RESET;
            position_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                unique case (pfq_pkg::cfg_index_t'(cfg_index))
                    pfq_pkg::REG_RATE_HZ:     rate_hz_reg     <= cfg_data[pfq_pkg::RATE_W-1:0];
                    pfq_pkg::REG_CLIP_LENGTH: clip_length_reg <= cfg_data[pfq_pkg::CLIP_W-1:0];
                    default:                  rate_hz_reg     <= rate_hz_reg;
                endcase
            end
            if (in_accept)
            begin
                position_reg <= position_next;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            pfq_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    mag_reg <= mag_in;
                    neg_reg <= raw_in[pfq_pkg::SAMPLE_W-1];
                    nan_reg <= not_a_number;
                    end_reg <= last_in;
                    idx_reg <= idx_in;
                end
            end
            pfq_pkg::ST_FADE_LEN:
            begin
                fo_reg <= mul_p[pfq_pkg::RECIP_SHIFT +: pfq_pkg::FO_W];
            end
            pfq_pkg::ST_FADE_FLAGS:
            begin
                fi_cap_reg    <= fi_cap;
                fo_cap_reg    <= fo_cap;
                fade_in_reg   <= (fi_cap != '0) && (idx_reg < pfq_pkg::CLIP_W'(fi_cap));
                fade_tail_reg <= (fo_cap != '0)
                                 && (idx_reg >= n_len - pfq_pkg::CLIP_W'(fo_cap));
            end
            pfq_pkg::ST_NUM:
            begin
                num_reg <= mul_p[pfq_pkg::NUM_W-1:0];
            end
            pfq_pkg::ST_DEN:
            begin
                den_reg <= mul_p[pfq_pkg::DEN_W-1:0];
            end
            pfq_pkg::ST_PROD:
            begin
                prod_reg <= mul_p;
            end
            pfq_pkg::ST_SCALE:
            begin
                clamp_reg   <= (prod_reg >= pfq_pkg::PROD_W'(limit));
                rem_reg     <= scaled;
                dsh_reg     <= (pfq_pkg::REM_W-1)'(limit) << (pfq_pkg::DIV_STEPS - 1);
                quo_reg     <= '0;
                div_cnt_reg <= pfq_pkg::DIV_CNT_W'(pfq_pkg::DIV_STEPS - 1);
            end
            pfq_pkg::ST_DIVIDE:
            begin
                if (div_ge)
                begin
                    rem_reg <= rem_reg - dsh_ext;
                end
                quo_reg     <= {quo_reg[pfq_pkg::DIV_STEPS-2:0], div_ge};
                dsh_reg     <= dsh_reg >> 1;
                div_cnt_reg <= div_cnt_reg - pfq_pkg::DIV_CNT_W'(1);
            end
            pfq_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    clip_end_reg <= end_reg;
                    if (nan_reg)
                    begin
                        pcm_sample_reg <= '0;
                    end
                    else if (neg_reg)
                    begin
                        pcm_sample_reg <= -$signed(mag_res_ext);
                    end
                    else
                    begin
                        pcm_sample_reg <= $signed(mag_res_ext);
                    end
                end
            end
            default:
            begin
                nan_reg <= nan_reg;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign pcm_sample = pcm_sample_reg;
    assign clip_end   = clip_end_reg;

endmodule

`default_nettype wire

/* src/pfq_checker.sv */
// Port-level checks for the PCM fade quantiser, bound to the top level.
`default_nettype none

module pfq_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                in_valid,
    input wire logic                                in_stall,
    input wire logic                                out_valid,
    input wire logic                                out_stall,
    input wire logic signed [pfq_pkg::PCM_W-1:0]    pcm_sample,
    input wire logic                                clip_end
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(pcm_sample) && $stable(clip_end)))
        else $error("stalled result changed");

    // Output is symmetric: the most negative code never appears
    a_pcm_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pcm_sample != {1'b1, {(pfq_pkg::PCM_W-1){1'b0}}}))
        else $error("pcm_sample outside symmetric range");

    // One transaction in flight: busy straight after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while busy");

    // A new result only appears at the end of a computation
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without work");

endmodule

bind pcm_fade_quantizer_top pfq_checker u_pfq_checker (.*);

`default_nettype wire

/* bench/pcm_fade_checker.sv */
// Checker for the PCM fade quantiser: predicts each sample from the observed traffic and compares.
module pcm_fade_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [pfq_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [pfq_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic signed [pfq_pkg::SAMPLE_W-1:0] sample_value,
    input  logic                                not_a_number,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic signed [pfq_pkg::PCM_W-1:0]    pcm_sample,
    input  logic                                clip_end,
    output int                                  failures,
    output int                                  pending,
    output int                                  samples_seen,
    output int                                  clip_ends_seen,
    output int                                  writes_seen,
    output int                                  invalid_seen
);
    import pfq_pkg::*;

    localparam longint unsigned FADE_IN_DIV   = 200;
    localparam longint unsigned TAIL_FADE_MUL = 40;
    localparam longint unsigned TAIL_FADE_DIV = 1000;
    localparam longint unsigned FULL_SCALE    = 32767;
    localparam longint unsigned SIGN_WRAP     = 64'h1_0000_0000;

    typedef struct packed {
        logic signed [PCM_W-1:0] pcm;
        logic                    last;
    } pcm_result_t;

    pcm_result_t              expected_pcm[$];
    pcm_result_t              oldest;
    logic [RATE_W-1:0]        rate_q;
    logic [CLIP_W-1:0]        clip_q;
    logic [POSITION_BITS-1:0] position_q;

    task automatic report_mismatch(input string what);
        failures++;
        $display("%0t checker: %s", $time, what);
    endtask

    // Work out the PCM sample for one input and move the clip position on.
    function automatic pcm_result_t quantise_and_advance(input logic [SAMPLE_W-1:0] raw,
                                                         input logic invalid);
        longint unsigned n, fade_in, fade_tail, idx, num, den, mag, q, lim, whole, rem, m;
        logic            neg;
        pcm_result_t     r;
        n = clip_q;
        if (n == 0)
        begin
            n = 1;
        end
        fade_in   = rate_q;
        fade_in   = fade_in / FADE_IN_DIV;
        fade_tail = rate_q;
        fade_tail = fade_tail * TAIL_FADE_MUL / TAIL_FADE_DIV;
        if (fade_in > n / 2)
        begin
            fade_in = n / 2;
        end
        if (fade_tail > n / 2)
        begin
            fade_tail = n / 2;
        end
        idx = position_q;
        // restart a position left beyond a shortened clip
        if (idx >= n)
        begin
            idx = 0;
        end
        num = 1;
        den = 1;
        if (fade_in > 0 && idx < fade_in)
        begin
            num = num * idx;
            den = den * fade_in;
        end
        if (fade_tail > 0 && idx >= n - fade_tail)
        begin
            num = num * (n - 1 - idx);
            den = den * fade_tail;
        end
        neg = raw[SAMPLE_W-1];
        mag = raw;
        if (neg)
        begin
            mag = SIGN_WRAP - mag;
        end
        r.pcm = '0;
        if (!invalid)
        begin
            q   = mag * num;
            lim = den << FRAC_BITS;
            if (q >= lim)
            begin
                m = FULL_SCALE;
            end
            else
            begin
                whole = q / den;
                rem   = q % den;
                m     = (whole * FULL_SCALE + rem * FULL_SCALE / den) >> FRAC_BITS;
            end
            r.pcm = PCM_W'(m);
            if (neg)
            begin
                r.pcm = -r.pcm;
            end
        end
        r.last = (idx == n - 1);
        if (r.last)
        begin
            position_q = '0;
        end
        else
        begin
            position_q = POSITION_BITS'(idx + 1);
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_q     = RATE_RESET;
            clip_q     = CLIP_RESET;
            position_q = '0;
            expected_pcm.delete();
            pending        = 0;
            failures       = 0;
            samples_seen   = 0;
            clip_ends_seen = 0;
            writes_seen    = 0;
            invalid_seen   = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                writes_seen++;
                case (cfg_index)
                    REG_RATE_HZ:     rate_q = cfg_data[RATE_W-1:0];
                    REG_CLIP_LENGTH: clip_q = cfg_data[CLIP_W-1:0];
                    default: report_mismatch("register write to an unknown index");
                endcase
            end
            if (in_valid && !in_stall)
            begin
                expected_pcm.push_back(quantise_and_advance(sample_value, not_a_number));
                samples_seen++;
                if (not_a_number)
                begin
                    invalid_seen++;
                end
            end
            if (out_valid && !out_stall)
            begin
                if (expected_pcm.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d (clip_end %0b) with no sample outstanding",
                                              pcm_sample, clip_end));
                end
                else
                begin
                    oldest = expected_pcm.pop_front();
                    if (pcm_sample !== oldest.pcm)
                    begin
                        report_mismatch($sformatf("pcm_sample %0d, predicted %0d",
                                                  pcm_sample, oldest.pcm));
                    end
                    if (clip_end !== oldest.last)
                    begin
                        report_mismatch($sformatf("clip_end %0b, predicted %0b",
                                                  clip_end, oldest.last));
                    end
                    if (clip_end === 1'b1)
                    begin
                        clip_ends_seen++;
                    end
                end
            end
            pending = expected_pcm.size();
        end
    end
endmodule

/* bench/testbench.sv */
// Top of the PCM fade quantiser bench: clock, reset, stimulus, receiver and verdict.
module testbench;
    import pfq_pkg::*;

    localparam int HALF_PERIOD     = 10;
    localparam int RESET_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 30;
    localparam int PHASES          = 12;
    localparam int PRESSURE_PHASE  = 6;
    localparam int SHORT_RUN       = 6;
    localparam int EXTREMES        = 18;
    localparam int PICK_RANDOM     = -1;

    logic                    clk          = 1'b0;
    logic                    rst_n        = 1'b0;
    logic                    cfg_write    = 1'b0;
    logic [CFG_INDEX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0]   cfg_data     = '0;
    logic                    in_valid     = 1'b0;
    logic                    in_stall;
    logic signed [SAMPLE_W-1:0] sample_value = '0;
    logic                    not_a_number = 1'b0;
    logic                    out_valid;
    logic                    out_stall    = 1'b0;
    logic signed [PCM_W-1:0] pcm_sample;
    logic                    clip_end;

    int failures, pending, samples_seen, clip_ends_seen, writes_seen, invalid_seen;

    bit idling_on     = 1'b1;
    bit hold_req      = 1'b0;
    bit hold_taken    = 1'b0;
    int hold_left     = 0;
    int rx_stall_left = 0;
    int quiet_cycles  = 0;

    logic [SAMPLE_W-1:0] extreme_samples[EXTREMES] = '{
        32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
        32'h0080_0000, 32'hFF80_0000, 32'h007F_FFFF, 32'hFF80_0001, 32'h0080_0001,
        32'hFF7F_FFFF, 32'h0040_0000, 32'hFFC0_0000, 32'h0000_0100, 32'h5555_5555,
        32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA
    };
    logic extreme_invalid[EXTREMES] = '{
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1
    };

    always #HALF_PERIOD clk = ~clk;

    pcm_fade_quantizer_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample_value (sample_value),
        .not_a_number (not_a_number),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pcm_sample   (pcm_sample),
        .clip_end     (clip_end)
    );

    pcm_fade_checker pcm_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sample_value   (sample_value),
        .not_a_number   (not_a_number),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pcm_sample     (pcm_sample),
        .clip_end       (clip_end),
        .failures       (failures),
        .pending        (pending),
        .samples_seen   (samples_seen),
        .clip_ends_seen (clip_ends_seen),
        .writes_seen    (writes_seen),
        .invalid_seen   (invalid_seen)
    );

    // Receiver: random stall bursts, plus one long hold-off on request.
    always @(negedge clk)
    begin
        if (hold_req && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left  = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (rx_stall_left > 0)
        begin
            rx_stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (idling_on && $urandom_range(0, 7) == 0)
            begin
                rx_stall_left = $urandom_range(1, 5);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    // Mix of full-range, in-range, near full-scale and quiet samples.
    function automatic logic [SAMPLE_W-1:0] draw_sample();
        logic [SAMPLE_W-1:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = $urandom_range(0, 32'h0080_0000);
            2: v = 32'h0080_0000 - 16 + $urandom_range(0, 32);
            default: v = $urandom_range(0, 4095);
        endcase
        if ($urandom_range(0, 1) == 1)
        begin
            v = -v;
        end
        return v;
    endfunction

    // Entered and left just after a falling edge; holds the transaction until accepted.
    task automatic send_sample(input logic [SAMPLE_W-1:0] v, input logic invalid);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        in_valid     <= 1'b1;
        sample_value <= v;
        not_a_number <= invalid;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic configure(input int rate, input int clip);
        cfg_write <= 1'b1;
        cfg_index <= REG_RATE_HZ;
        cfg_data  <= CFG_DATA_W'(rate);
        @(negedge clk);
        cfg_index <= REG_CLIP_LENGTH;
        cfg_data  <= CFG_DATA_W'(clip);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        // all-ones rate checks that bits above the register width are dropped
        int phase_rate[PHASES]  = '{192000, 24000, 0, 262143, 16777215, 200,
                                    PICK_RANDOM, 8000, 199, PICK_RANDOM, 1, 48000};
        int phase_clip[PHASES]  = '{101, 1200, 0, 16777215, 40, 3,
                                    PICK_RANDOM, 64, 2, PICK_RANDOM, 1, 500};
        int phase_count[PHASES] = '{200, 200, 60, 120, 150, 120, 200, 150, 80, 150, 50, 130};
        int rate;
        int clip;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset values of the registers: fade-in from position zero
        for (int k = 0; k < SHORT_RUN; k++)
        begin
            send_sample(extreme_samples[k], extreme_invalid[k]);
        end
        drain_results();
        // no fade, and the position is now beyond the shortened clip
        configure(1, 5);
        for (int k = 0; k < EXTREMES; k++)
        begin
            send_sample(extreme_samples[k], extreme_invalid[k]);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            drain_results();
            rate = (phase_rate[p] == PICK_RANDOM) ? $urandom_range(1, 192000) : phase_rate[p];
            clip = (phase_clip[p] == PICK_RANDOM) ? $urandom_range(2, 3000) : phase_clip[p];
            configure(rate, clip);
            idling_on = (p != PHASES - 1);
            for (int k = 0; k < phase_count[p]; k++)
            begin
                if (p == PRESSURE_PHASE && k == 30)
                begin
                    hold_req = 1'b1;
                end
                send_sample(draw_sample(), $urandom_range(0, 15) == 0);
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("summary: %0d samples (%0d flagged invalid) across %0d register writes",
                 samples_seen, invalid_seen, writes_seen);
        $display("summary: %0d clip ends, fades on short and long clips, one %0d-cycle hold-off",
                 clip_ends_seen, HOLD_OFF_CYCLES);
        if (failures == 0)
        begin
            $display("testbench: PASS");
        end
        else
        begin
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule
